### hw/rtl/pwm_encoder_median_decoder_core_macros.svh
// Assertion macros shared by the decoder RTL.
// Depends on nothing; define ASSERT_OFF to drop all checks.
`ifndef PWM_ENCODER_MEDIAN_DECODER_CORE_MACROS_SVH
`define PWM_ENCODER_MEDIAN_DECODER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

### hw/rtl/pemd_pkg.sv
// Shared types and constants for the PWM encoder median decoder.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package pemd_pkg;
  localparam int unsigned WindowDepth = 5;
  localparam int unsigned SlotW = $clog2(WindowDepth + 1);
  localparam int unsigned WidthW = 16;
  localparam int unsigned PeriodW = 17;
  localparam int unsigned PosW = 12;
  localparam int unsigned ScaleNum = 4098;
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] RegEnable = 2'd0;
  localparam logic [1:0] RegMaxWidth = 2'd1;
  localparam logic [1:0] RegMaxPeriod = 2'd2;

  // Snapshot of both windows handed from front to back
  typedef struct packed {
    logic [WindowDepth-1:0][WidthW-1:0] high;
    logic [WindowDepth-1:0][WidthW-1:0] low;
  } window_t;
endpackage
`default_nettype wire

### hw/rtl/pwm_encoder_median_decoder_core.sv
// PWM encoder decoder top level. A queued falling edge passes to its result
// through the queue handoff, a median scan of each window slot, a multiply,
// the bit-serial divide steps and a finish step. The back end takes no new
// snapshot until the last result is popped; edges are taken each cycle while the 2-entry
// snapshot queue has room. Reset (rst_ni low, async) clears edge state,
// windows, queue and registers to enable 0, max_width 4097, max_period 4098.
`timescale 1ns / 1ps
`default_nettype none
module pwm_encoder_median_decoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic        edge_level_i,
  input  wire logic [31:0] edge_time_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [11:0]      position_o,
  output logic [15:0]      median_high_o,
  output logic [15:0]      median_low_o
);
  logic enable_q;
  logic [15:0] max_width_q;
  logic [16:0] max_period_q;
  logic snap_valid, snap_ready;
  pemd_pkg::window_t snap;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      max_width_q <= 16'd4097;
      max_period_q <= 17'd4098;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pemd_pkg::RegEnable:    enable_q <= cfg_data_i[0];
        pemd_pkg::RegMaxWidth:  max_width_q <= cfg_data_i[15:0];
        pemd_pkg::RegMaxPeriod: max_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pemd_front u_front (
    .clk_i, .rst_ni,
    .enable_i(enable_q), .max_width_i(max_width_q), .max_period_i(max_period_q),
    .push_i(push), .full_o(full), .edge_level_i, .edge_time_i,
    .snap_valid_o(snap_valid), .snap_ready_i(snap_ready), .snap_o(snap)
  );

  pemd_back u_back (
    .clk_i, .rst_ni,
    .snap_valid_i(snap_valid), .snap_ready_o(snap_ready), .snap_i(snap),
    .empty_o(empty), .pop_i(pop),
    .position_o, .median_high_o, .median_low_o
  );
endmodule
`default_nettype wire

### hw/rtl/pemd_front.sv
// Front end: measures pulse widths, updates ring buffers, queues window snapshots.
// Depends on pemd_pkg and the core macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "pwm_encoder_median_decoder_core_macros.svh"
module pemd_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            enable_i,
  input  wire logic [pemd_pkg::WidthW-1:0]     max_width_i,
  input  wire logic [pemd_pkg::PeriodW-1:0]    max_period_i,
  input  wire logic                            push_i,
  output logic                                 full_o,
  input  wire logic                            edge_level_i,
  input  wire logic [31:0]                     edge_time_i,
  output logic                                 snap_valid_o,
  input  wire logic                            snap_ready_i,
  output pemd_pkg::window_t                    snap_o
);
  localparam int unsigned D = pemd_pkg::WindowDepth;
  localparam int unsigned QAW = $clog2(pemd_pkg::QueueDepth);

  logic [31:0] rise_time_q, fall_time_q;
  logic rise_seen_q, fall_seen_q;
  logic [D-1:0][pemd_pkg::WidthW-1:0] high_q, low_q;
  logic [pemd_pkg::SlotW-1:0] slot_q;

  pemd_pkg::window_t queue_q [pemd_pkg::QueueDepth];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0] count_q;

  logic [pemd_pkg::SlotW-1:0] slot;
  logic [31:0] w;
  logic w_ok;
  logic [D-1:0][pemd_pkg::WidthW-1:0] high_n;
  logic [pemd_pkg::PeriodW-1:0] period;
  logic accept, enq, deq;

  assign full_o = (count_q == (QAW+1)'(pemd_pkg::QueueDepth));
  assign accept = push_i && !full_o;
  assign slot = (slot_q < pemd_pkg::SlotW'(D)) ? slot_q : '0;
  assign w = edge_level_i ? (edge_time_i - fall_time_q) : (edge_time_i - rise_time_q);
  assign w_ok = (w != 32'd0) && (w <= {16'd0, max_width_i});

  // Compute the high window after a falling edge and its period check
  always_comb begin
    high_n = high_q;
    if (rise_seen_q && w_ok) high_n[slot] = w[pemd_pkg::WidthW-1:0];
    period = {1'b0, high_n[slot]} + {1'b0, low_q[slot]};
  end

  assign enq = accept && enable_i && !edge_level_i && (!rise_seen_q || w_ok)
               && (period != '0) && (period <= max_period_i);
  assign deq = snap_valid_o && snap_ready_i;

  // Update edge state and ring buffers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_time_q <= '0;
      fall_time_q <= '0;
      rise_seen_q <= 1'b0;
      fall_seen_q <= 1'b0;
      high_q <= '0;
      low_q <= '0;
      slot_q <= '0;
    end else if (accept && enable_i) begin
      if (edge_level_i) begin
        rise_time_q <= edge_time_i;
        rise_seen_q <= 1'b1;
        if (fall_seen_q && w_ok) low_q[slot] <= w[pemd_pkg::WidthW-1:0];
      end else begin
        fall_time_q <= edge_time_i;
        fall_seen_q <= 1'b1;
        high_q <= high_n;
        if (enq) slot_q <= (slot == pemd_pkg::SlotW'(D-1)) ? '0 : slot + 1'b1;
      end
    end
  end

  // Snapshot queue storage
  always_ff @(posedge clk_i) begin
    if (enq) queue_q[wr_ptr_q] <= '{high: high_n, low: low_q};
  end

  // Advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (enq) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (deq) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + (QAW+1)'(enq) - (QAW+1)'(deq);
    end
  end

  assign snap_valid_o = (count_q != '0);
  assign snap_o = queue_q[rd_ptr_q];

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, enq && full_o)
  `ASSERT_IMPL(a_slot_range, clk_i, rst_ni, slot_q < pemd_pkg::SlotW'(D))
  `ASSERT_IMPL(a_count_range, clk_i, rst_ni,
               count_q <= (QAW+1)'(pemd_pkg::QueueDepth))
endmodule
`default_nettype wire

### hw/rtl/pemd_back.sv
// Back end: sequential median selection, restoring division, result register.
// Depends on pemd_pkg and the core macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "pwm_encoder_median_decoder_core_macros.svh"
module pemd_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         snap_valid_i,
  output logic                              snap_ready_o,
  input  pemd_pkg::window_t                 snap_i,
  output logic                              empty_o,
  input  wire logic                         pop_i,
  output logic [pemd_pkg::PosW-1:0]         position_o,
  output logic [pemd_pkg::WidthW-1:0]       median_high_o,
  output logic [pemd_pkg::WidthW-1:0]       median_low_o
);
  localparam int unsigned D = pemd_pkg::WindowDepth;
  localparam int unsigned IW = $clog2(D + 1);
  localparam int unsigned NumW = 29;   // 16-bit median times 4098
  localparam int unsigned DivCW = $clog2(NumW + 1);

  typedef enum logic [2:0] {
    StIdle, StMedian, StMul, StDiv, StFinish, StHold
  } state_e;

  state_e state_q;
  pemd_pkg::window_t win_q;
  logic [IW-1:0] cand_q;
  logic [pemd_pkg::WidthW-1:0] mh_q, ml_q;
  logic [NumW-1:0] num_q, quo_q;
  logic [pemd_pkg::PeriodW:0] rem_q;
  logic [pemd_pkg::PeriodW-1:0] sum_q;
  logic [DivCW-1:0] bit_q;
  logic [pemd_pkg::PosW-1:0] pos_q;
  logic mh_done_q, ml_done_q;

  // Median test of one candidate: count elements below and at-or-below
  logic [IW-1:0] hl, hle, ll, lle;
  logic h_is_med, l_is_med;
  always_comb begin
    hl = '0; hle = '0; ll = '0; lle = '0;
    for (int k = 0; k < D; k++) begin
      hl  = hl  + IW'(win_q.high[k] <  win_q.high[cand_q]);
      hle = hle + IW'(win_q.high[k] <= win_q.high[cand_q]);
      ll  = ll  + IW'(win_q.low[k]  <  win_q.low[cand_q]);
      lle = lle + IW'(win_q.low[k]  <= win_q.low[cand_q]);
    end
    h_is_med = (hl <= IW'(D/2)) && (hle > IW'(D/2));
    l_is_med = (ll <= IW'(D/2)) && (lle > IW'(D/2));
  end

  logic [pemd_pkg::PeriodW:0] rem_sh;
  assign rem_sh = {rem_q[pemd_pkg::PeriodW-1:0], num_q[NumW-1]};

  assign snap_ready_o = (state_q == StIdle);
  assign empty_o = (state_q != StHold);
  assign position_o = pos_q;
  assign median_high_o = mh_q;
  assign median_low_o = ml_q;

  // Sequence one snapshot through median, multiply, divide
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      win_q <= '0;
      cand_q <= '0;
      mh_q <= '0;
      ml_q <= '0;
      num_q <= '0;
      quo_q <= '0;
      rem_q <= '0;
      sum_q <= '0;
      bit_q <= '0;
      pos_q <= '0;
      mh_done_q <= 1'b0;
      ml_done_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: if (snap_valid_i) begin
          win_q <= snap_i;
          cand_q <= '0;
          mh_done_q <= 1'b0;
          ml_done_q <= 1'b0;
          state_q <= StMedian;
        end
        StMedian: begin
          if (!mh_done_q && h_is_med) begin
            mh_q <= win_q.high[cand_q];
            mh_done_q <= 1'b1;
          end
          if (!ml_done_q && l_is_med) begin
            ml_q <= win_q.low[cand_q];
            ml_done_q <= 1'b1;
          end
          if (cand_q == IW'(D-1)) state_q <= StMul;
          else cand_q <= cand_q + 1'b1;
        end
        StMul: begin
          num_q <= NumW'(mh_q) * NumW'(pemd_pkg::ScaleNum);
          sum_q <= {1'b0, mh_q} + {1'b0, ml_q};
          rem_q <= '0;
          bit_q <= DivCW'(NumW);
          state_q <= ({1'b0, mh_q} + {1'b0, ml_q} == '0) ? StIdle : StDiv;
        end
        StDiv: begin
          if (rem_sh >= {1'b0, sum_q}) begin
            rem_q <= rem_sh - {1'b0, sum_q};
            quo_q <= {quo_q[NumW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[NumW-2:0], 1'b0};
          end
          num_q <= {num_q[NumW-2:0], 1'b0};
          bit_q <= bit_q - 1'b1;
          if (bit_q == DivCW'(1)) state_q <= StFinish;
        end
        StFinish: begin
          // quotient q gives position q-1, clamped to 0..4095; above 4097 drops the result
          if (quo_q > NumW'(4097)) state_q <= StIdle;
          else begin
            if (quo_q == '0) pos_q <= '0;
            else if (quo_q >= NumW'(4096)) pos_q <= '1;
            else pos_q <= pemd_pkg::PosW'(quo_q - 1'b1);
            state_q <= StHold;
          end
        end
        StHold: if (pop_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  `ASSERT_IMPL(a_hold_stable, clk_i, rst_ni,
               (state_q == StHold && !pop_i) |=> $stable(position_o))
  `ASSERT_IMPL(a_div_nonzero, clk_i, rst_ni, (state_q == StDiv) |-> (sum_q != '0))
  `ASSERT_IMPL(a_medians_found, clk_i, rst_ni,
               (state_q == StMul) |-> (mh_done_q && ml_done_q))
endmodule
`default_nettype wire
